// File: rtl/dfr_pkg.sv
// Package with shared types and constants for the datagram fragment reassembler.
`default_nettype none

package dfr_pkg;

    localparam int DFR_FRAME_BYTES = 255;
    localparam int CFG_ADDR_W = 3;

    localparam logic [15:0] BUFFER_LENGTH_RESET = 16'hFFFF;
    localparam logic [CFG_ADDR_W-1:0] REG_BUFFER_LENGTH = 3'd0;

    localparam logic [7:0] IDX_FLAGS = 8'd0;
    localparam logic [7:0] IDX_SOURCE = 8'd1;
    localparam logic [7:0] IDX_SEQ_HI = 8'd2;
    localparam logic [7:0] IDX_SEQ_LO = 8'd3;
    localparam logic [7:0] IDX_OFFSET_HI = 8'd6;
    localparam logic [7:0] IDX_OFFSET_LO = 8'd7;
    localparam logic [7:0] IDX_PAYLOAD = 8'd8;

    localparam int FLAG_MORE = 0;
    localparam int FLAG_ENCRYPTED = 1;

    typedef struct packed {
        logic        has_result;
        logic        write_enable;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic        message_done;
        logic [15:0] received_length;
        logic        encrypted_flag;
        logic [7:0]  source_address;
    } t_dfr_result;

endpackage

`default_nettype wire

// File: rtl/datagram_fragment_reassembler.sv
// Top level of the datagram fragment reassembler: handshakes, registers and result stage.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall    i_frame_byte, i_frame_last
// out       output     o_out_valid / i_out_stall  write, done, length, flag, source
// cfg       input      APB psel/penable/pwrite   buffer_length at byte address 0
//
// One frame byte is taken per cycle while o_in_stall is low; it is registered on entry.
// The per-byte header update and length accounting sit between the input
// register and the result register, so a stalled result only holds the pipe.
// Reset is synchronous and active low; it clears all control and message state
// and sets buffer_length to 65535. No clearing pass is needed.

module datagram_fragment_reassembler
    import dfr_pkg::*;
#(
    parameter int FRAME_BYTES = DFR_FRAME_BYTES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [7:0]            i_frame_byte,
    input  wire logic                  i_frame_last,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_write_enable,
    output logic [15:0]                o_write_address,
    output logic [7:0]                 o_write_data,
    output logic                       o_message_done,
    output logic [15:0]                o_received_length,
    output logic                       o_encrypted_flag,
    output logic [7:0]                 o_source_address,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    t_dfr_result r_out;
    logic [15:0] r_buffer_length;
    logic        advance;
    logic        load;
    t_dfr_result core_result;

    assign advance = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign load = i_in_valid && !o_in_stall;

    assign pready = 1'b1;
    assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_BUFFER_LENGTH[CFG_ADDR_W-1:2]) ?
                    {16'b0, r_buffer_length} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_length <= BUFFER_LENGTH_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[CFG_ADDR_W-1:2] == REG_BUFFER_LENGTH[CFG_ADDR_W-1:2]) begin
            r_buffer_length <= pwdata[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_in_byte <= i_frame_byte;
            r_in_last <= i_frame_last;
        end
    end

    dfr_core #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (advance),
        .i_byte         (r_in_byte),
        .i_last         (r_in_last),
        .i_buffer_length(r_buffer_length),
        .o_result       (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= core_result.has_result;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_write_enable = r_out.write_enable;
    assign o_write_address = r_out.write_address;
    assign o_write_data = r_out.write_data;
    assign o_message_done = r_out.message_done;
    assign o_received_length = r_out.received_length;
    assign o_encrypted_flag = r_out.encrypted_flag;
    assign o_source_address = r_out.source_address;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_write_enable || o_message_done))
        else $error("Result item carries neither a write nor a completion.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_write_enable) |-> (o_write_address == 16'd0 && o_write_data == 8'd0))
        else $error("Unused write fields are not zero.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_message_done) |-> (o_received_length == 16'd0))
        else $error("Received length shown without completion.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("Input stalled while the pipe could move.");

endmodule

`default_nettype wire

// File: rtl/dfr_core.sv
// Header parsing, message matching and length accounting for one frame byte per step.
`default_nettype none

module dfr_core
    import dfr_pkg::*;
#(
    parameter int FRAME_BYTES = DFR_FRAME_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_last,
    input  wire logic [15:0] i_buffer_length,
    output t_dfr_result      o_result
);

    localparam logic [7:0] FrameLimit = 8'(FRAME_BYTES);

    logic [7:0]  r_byte_index, n_byte_index;
    logic [7:0]  r_frame_flags, n_frame_flags;
    logic [7:0]  r_frame_source, n_frame_source;
    logic [15:0] r_frame_sequence, n_frame_sequence;
    logic [15:0] r_frame_offset, n_frame_offset;
    logic        r_frame_dropped, n_frame_dropped;
    logic [15:0] r_message_sequence, n_message_sequence;
    logic [7:0]  r_message_source, n_message_source;
    logic        r_message_encrypted, n_message_encrypted;
    logic [15:0] r_received_count, n_received_count;

    always_comb begin
        logic [7:0]  p;
        logic [7:0]  rel;
        logic [16:0] pos;
        logic [7:0]  data;
        logic [16:0] end_pos;
        logic [15:0] add;
        logic [16:0] sum;
        logic [15:0] count_sat;
        logic        done;

        p = r_byte_index;
        rel = p - IDX_PAYLOAD;
        pos = {1'b0, r_frame_offset} + {9'b0, rel};
        data = 8'd0;
        end_pos = 17'd0;
        add = 16'd0;
        sum = 17'd0;
        count_sat = 16'd0;
        done = 1'b0;

        n_byte_index = r_byte_index;
        n_frame_flags = r_frame_flags;
        n_frame_source = r_frame_source;
        n_frame_sequence = r_frame_sequence;
        n_frame_offset = r_frame_offset;
        n_frame_dropped = r_frame_dropped;
        n_message_sequence = r_message_sequence;
        n_message_source = r_message_source;
        n_message_encrypted = r_message_encrypted;
        n_received_count = r_received_count;

        o_result = '0;

        if (p < FrameLimit) begin
            case (p)
                IDX_FLAGS: begin
                    n_frame_flags = i_byte;
                end
                IDX_SOURCE: begin
                    n_frame_source = i_byte;
                end
                IDX_SEQ_HI: begin
                    n_frame_sequence = {i_byte, r_frame_sequence[7:0]};
                end
                IDX_SEQ_LO: begin
                    n_frame_sequence = {r_frame_sequence[15:8], i_byte};
                end
                IDX_OFFSET_HI: begin
                    n_frame_offset = {i_byte, r_frame_offset[7:0]};
                end
                IDX_OFFSET_LO: begin
                    n_frame_offset = {r_frame_offset[15:8], i_byte};
                    if (r_received_count == 16'd0) begin
                        n_message_sequence = r_frame_sequence;
                        n_message_source = r_frame_source;
                        n_message_encrypted = r_frame_flags[FLAG_ENCRYPTED];
                        n_frame_dropped = 1'b0;
                    end else if (r_message_sequence != r_frame_sequence ||
                                 r_message_source != r_frame_source) begin
                        n_frame_dropped = 1'b1;
                    end
                end
                default: begin
                    if (p >= IDX_PAYLOAD && !r_frame_dropped &&
                        pos < {1'b0, i_buffer_length}) begin
                        o_result.write_enable = 1'b1;
                        o_result.write_address = pos[15:0];
                        o_result.write_data = i_byte;
                    end
                end
            endcase
            n_byte_index = p + 8'd1;
        end

        if (i_last) begin
            if (n_byte_index >= IDX_PAYLOAD && !n_frame_dropped) begin
                data = n_byte_index - IDX_PAYLOAD;
                end_pos = {1'b0, n_frame_offset} + {9'b0, data};
                if (end_pos > {1'b0, i_buffer_length}) begin
                    add = (i_buffer_length > n_frame_offset) ?
                          i_buffer_length - n_frame_offset : 16'd0;
                    done = 1'b1;
                end else begin
                    add = {8'b0, data};
                    done = !n_frame_flags[FLAG_MORE];
                end
                sum = {1'b0, r_received_count} + {1'b0, add};
                count_sat = sum[16] ? 16'hFFFF : sum[15:0];
                if (done) begin
                    o_result.received_length = count_sat;
                    n_received_count = 16'd0;
                end else begin
                    n_received_count = count_sat;
                end
            end
            n_byte_index = 8'd0;
            n_frame_dropped = 1'b0;
        end

        o_result.message_done = done;
        o_result.encrypted_flag = n_message_encrypted;
        o_result.source_address = n_message_source;
        o_result.has_result = o_result.write_enable || done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_frame_flags <= '0;
            r_frame_source <= '0;
            r_frame_sequence <= '0;
            r_frame_offset <= '0;
            r_frame_dropped <= 1'b0;
            r_message_sequence <= '0;
            r_message_source <= '0;
            r_message_encrypted <= 1'b0;
            r_received_count <= '0;
        end else if (i_step) begin
            r_byte_index <= n_byte_index;
            r_frame_flags <= n_frame_flags;
            r_frame_source <= n_frame_source;
            r_frame_sequence <= n_frame_sequence;
            r_frame_offset <= n_frame_offset;
            r_frame_dropped <= n_frame_dropped;
            r_message_sequence <= n_message_sequence;
            r_message_source <= n_message_source;
            r_message_encrypted <= n_message_encrypted;
            r_received_count <= n_received_count;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index <= FrameLimit)
        else $error("Byte index ran past the frame limit.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.message_done) |=> (r_received_count == 16'd0))
        else $error("Received count not cleared after message completion.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.write_enable) |-> (r_byte_index >= IDX_PAYLOAD))
        else $error("Buffer write issued for a header byte.");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the datagram fragment reassembler, built on a byte-level predictor.
`timescale 1ns / 100ps

module testbench;
    import dfr_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [7:0]            i_frame_byte = 8'd0;
    logic                  i_frame_last = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_write_enable;
    logic [15:0]           o_write_address;
    logic [7:0]            o_write_data;
    logic                  o_message_done;
    logic [15:0]           o_received_length;
    logic                  o_encrypted_flag;
    logic [7:0]            o_source_address;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = 32'd0;
    logic [31:0]           prdata;
    logic                  pready;

    frame_byte_t frame_bytes_q[$];
    t_dfr_result buffer_events[$];
    frame_byte_t next_item;

    // Shadow of the block's header parser and message state.
    logic [7:0]  hdr_index = 8'd0;
    logic [7:0]  hdr_flags = 8'd0;
    logic [7:0]  hdr_source = 8'd0;
    logic [15:0] hdr_sequence = 16'd0;
    logic [15:0] hdr_offset = 16'd0;
    logic        frame_skip = 1'b0;
    logic [15:0] msg_sequence = 16'd0;
    logic [7:0]  msg_source = 8'd0;
    logic        msg_encrypted = 1'b0;
    int unsigned msg_count = 0;
    int unsigned buffer_limit = 65535;

    bit idle_on = 1'b1;
    bit hold_armed = 1'b0;
    logic long_hold = 1'b0;
    int send_gap = 0;
    int stall_left = 0;
    int fail_count = 0;
    int bytes_accepted = 0;
    int writes_checked = 0;
    int messages_checked = 0;
    int settings_used = 0;

    datagram_fragment_reassembler DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_frame_byte(i_frame_byte),
        .i_frame_last(i_frame_last),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_write_enable(o_write_enable),
        .o_write_address(o_write_address),
        .o_write_data(o_write_data),
        .o_message_done(o_message_done),
        .o_received_length(o_received_length),
        .o_encrypted_flag(o_encrypted_flag),
        .o_source_address(o_source_address),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    task automatic reassemble_byte(input logic [7:0] b, input logic last);
        int unsigned p;
        int unsigned pos;
        int unsigned frame_len;
        int unsigned frag_data;
        int unsigned credit;
        t_dfr_result ev;
        ev = '0;
        p = 32'(hdr_index);
        if (p < DFR_FRAME_BYTES) begin
            case (hdr_index)
                IDX_FLAGS: hdr_flags = b;
                IDX_SOURCE: hdr_source = b;
                IDX_SEQ_HI: hdr_sequence[15:8] = b;
                IDX_SEQ_LO: hdr_sequence[7:0] = b;
                IDX_OFFSET_HI: hdr_offset[15:8] = b;
                IDX_OFFSET_LO: begin
                    hdr_offset[7:0] = b;
                    if (msg_count == 0) begin
                        msg_sequence = hdr_sequence;
                        msg_source = hdr_source;
                        msg_encrypted = hdr_flags[FLAG_ENCRYPTED];
                        frame_skip = 1'b0;
                    end else if (msg_sequence != hdr_sequence || msg_source != hdr_source) begin
                        frame_skip = 1'b1;
                    end
                end
                default: begin
                    if (p >= IDX_PAYLOAD && !frame_skip) begin
                        pos = hdr_offset + p - IDX_PAYLOAD;
                        if (pos < buffer_limit) begin
                            ev.write_enable = 1'b1;
                            ev.write_address = pos[15:0];
                            ev.write_data = b;
                        end
                    end
                end
            endcase
            hdr_index = hdr_index + 8'd1;
        end
        if (last) begin
            frame_len = 32'(hdr_index);
            if (frame_len >= IDX_PAYLOAD && !frame_skip) begin
                frag_data = frame_len - IDX_PAYLOAD;
                if (hdr_offset + frag_data > buffer_limit) begin
                    credit = (buffer_limit > hdr_offset) ? buffer_limit - hdr_offset : 0;
                    ev.message_done = 1'b1;
                end else begin
                    credit = frag_data;
                    ev.message_done = !hdr_flags[FLAG_MORE];
                end
                msg_count = msg_count + credit;
                if (msg_count > 65535)
                    msg_count = 65535;
                if (ev.message_done) begin
                    ev.received_length = msg_count[15:0];
                    msg_count = 0;
                end
            end
            hdr_index = 8'd0;
            frame_skip = 1'b0;
        end
        if (ev.write_enable || ev.message_done) begin
            ev.has_result = 1'b1;
            ev.encrypted_flag = msg_encrypted;
            ev.source_address = msg_source;
            buffer_events.push_back(ev);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                reassemble_byte(i_frame_byte, i_frame_last);
                bytes_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 18);
                    i_in_valid <= 1'b0;
                end else if (frame_bytes_q.size() != 0) begin
                    next_item = frame_bytes_q.pop_front();
                    i_frame_byte <= next_item.data;
                    i_frame_last <= next_item.last;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    t_dfr_result got;
    t_dfr_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = '{has_result: 1'b1, write_enable: o_write_enable,
                        write_address: o_write_address, write_data: o_write_data,
                        message_done: o_message_done, received_length: o_received_length,
                        encrypted_flag: o_encrypted_flag, source_address: o_source_address};
                if (buffer_events.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display(
                            "%0t: unexpected result we=%0b addr=%h data=%h done=%0b len=%0d",
                            $time, got.write_enable, got.write_address, got.write_data,
                            got.message_done, got.received_length);
                end else begin
                    want = buffer_events.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display(
                                "%0t: expected we=%0b a=%h d=%h done=%0b len=%0d enc=%0b src=%h",
                                $time, want.write_enable, want.write_address, want.write_data,
                                want.message_done, want.received_length,
                                want.encrypted_flag, want.source_address);
                            $display(
                                "%0t: actual   we=%0b a=%h d=%h done=%0b len=%0d enc=%0b src=%h",
                                $time, got.write_enable, got.write_address, got.write_data,
                                got.message_done, got.received_length,
                                got.encrypted_flag, got.source_address);
                        end
                    end
                    if (want.write_enable)
                        writes_checked++;
                    if (want.message_done)
                        messages_checked++;
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 18);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= long_hold;
            end
        end
    end

    // The receiver stops taking results for a long stretch so the pipe backs up.
    initial begin
        wait (hold_armed);
        repeat (10) @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    initial begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void queue_frame(input logic [7:0] flags, input logic [7:0] src,
                                        input logic [15:0] seq, input logic [15:0] offset,
                                        input int frame_len);
        logic [7:0] hdr [8];
        frame_byte_t item;
        hdr[0] = flags;
        hdr[1] = src;
        hdr[2] = seq[15:8];
        hdr[3] = seq[7:0];
        hdr[4] = 8'($urandom);
        hdr[5] = 8'($urandom);
        hdr[6] = offset[15:8];
        hdr[7] = offset[7:0];
        for (int i = 0; i < frame_len; i++) begin
            item.data = (i < 8) ? hdr[i] : 8'($urandom);
            item.last = (i == frame_len - 1);
            frame_bytes_q.push_back(item);
        end
    endfunction

    task automatic queue_message(output int n);
        logic [15:0] seq;
        logic [15:0] off;
        logic [7:0] src;
        logic enc;
        int frags;
        int payload_bytes;
        seq = 16'($urandom);
        src = 8'($urandom);
        enc = 1'($urandom);
        frags = $urandom_range(1, 4);
        n = 0;
        case ($urandom_range(0, 3))
            0: off = 16'($urandom);
            1: off = (buffer_limit > 12) ? 16'(buffer_limit - $urandom_range(0, 12))
                                         : 16'($urandom_range(0, 3));
            default: off = 16'd0;
        endcase
        for (int f = 0; f < frags; f++) begin
            // A stray frame from another message, sometimes cut short inside its header.
            if ($urandom_range(0, 5) == 0)
                queue_frame(8'($urandom) & ~8'h01, src ^ 8'($urandom_range(1, 255)),
                            16'($urandom), 16'($urandom), $urandom_range(1, 14));
            payload_bytes = ($urandom_range(0, 15) == 0) ? $urandom_range(239, 260)
                                                         : $urandom_range(0, 14);
            queue_frame({6'($urandom), enc, ((f == frags - 1) ? 1'b0 : 1'b1)},
                        src, seq, off, payload_bytes + 8);
            n += payload_bytes + 8;
            off += (payload_bytes > 247) ? 16'd247 : 16'(payload_bytes);
        end
    endtask

    task automatic drain();
        while (frame_bytes_q.size() != 0 || i_in_valid || buffer_events.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_buffer_length(input logic [15:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_BUFFER_LENGTH;
        pwdata <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        buffer_limit = 32'(value);
        settings_used++;
    endtask

    task automatic run_messages(input int budget, input bit allow_idle);
        int queued;
        int n;
        queued = 0;
        while (queued < budget) begin
            while (frame_bytes_q.size() >= 16)
                @(posedge i_clk);
            idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            queue_message(n);
            queued += n;
        end
        drain();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_frame(8'hFF, 8'h00, 16'hFF00, 16'h0000, 3);
        queue_frame(8'h02, 8'hFF, 16'hFFFF, 16'h0000, 10);
        queue_frame(8'h01, 8'h00, 16'h0000, 16'hFFFE, 10);
        queue_frame(8'h00, 8'h00, 16'h0000, 16'h0000, 1);
        drain();

        write_buffer_length(16'd0);
        run_messages(10, 1'b1);
        write_buffer_length(16'd1);
        run_messages(10, 1'b1);
        write_buffer_length(16'd20);
        run_messages(30, 1'b1);
        write_buffer_length(16'($urandom_range(64, 700)));
        run_messages(50, 1'b1);
        write_buffer_length(16'hFFFF);
        hold_armed = 1'b1;
        run_messages(50, 1'b1);

        // Closing stretch with both sides running flat out.
        run_messages(30, 1'b0);

        $display("Sent %0d frame bytes under %0d buffer sizes: short, stray, overlong, truncated",
                 bytes_accepted, settings_used);
        $display("and multi-fragment frames; %0d buffer writes and %0d completed messages compared.",
                 writes_checked, messages_checked);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/dfr_pkg.sv
rtl/dfr_core.sv
rtl/datagram_fragment_reassembler.sv
tb/testbench.sv
